// ===== src/bdmt_pkg.sv =====
`default_nettype none
package bdmt_pkg;

   // Source frame limits and the derived address width of the column store.
   localparam int MaxWidth  = 4096;
   localparam int MaxHeight = 4096;
   localparam int ColW      = $clog2(MaxWidth);
   localparam int SideW     = 13;
   localparam int CntW      = 25;
   localparam int SumW      = 32;
   localparam int CsrIdxW   = 3;
   localparam int CsrDataW  = 13;

   localparam logic [SideW-1:0] MaxWidthSide  = SideW'(MaxWidth);
   localparam logic [SideW-1:0] MaxHeightSide = SideW'(MaxHeight);

   // Register indexes of the configuration port.
   localparam logic [CsrIdxW-1:0] CsrSrcWidth   = 3'd0;
   localparam logic [CsrIdxW-1:0] CsrSrcHeight  = 3'd1;
   localparam logic [CsrIdxW-1:0] CsrMaxSide    = 3'd2;
   localparam logic [CsrIdxW-1:0] CsrMaskEnable = 3'd3;
   localparam logic [CsrIdxW-1:0] CsrInvertMask = 3'd4;

   // Tint constants.
   localparam logic [7:0] TintOffset = 8'd150;
   localparam logic [7:0] MaskThresh = 8'd127;
   localparam logic [8:0] RecipThird = 9'd171;   // 171 / 512 ~ 1/3, exact for 8-bit values
   localparam int         RecipShift = 9;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic [7:0] mask_value;
   } req_type;

   typedef struct packed {
      logic [7:0] out_red;
      logic [7:0] out_green;
      logic [7:0] out_blue;
      logic       tinted;
      logic       row_end;
      logic       frame_end;
   } rsp_type;

   typedef struct packed {
      logic [SideW-1:0] width;
      logic [SideW-1:0] height;
      logic [SideW-1:0] side_budget;
      logic             mask_enable;
      logic             invert_mask;
   } cfg_type;

   // One finished block handed from the front end to the back end.
   typedef struct packed {
      logic [SumW-1:0] sum_red;
      logic [SumW-1:0] sum_green;
      logic [SumW-1:0] sum_blue;
      logic [CntW-1:0] count;
      logic            tint;
      logic            row_end;
      logic            frame_end;
   } job_type;

   // Queue status seen by the front end.
   typedef struct packed {
      logic full;
      logic empty;
   } qstat_type;

   typedef struct packed {
      logic [SumW-1:0] sum_red;
      logic [SumW-1:0] sum_green;
      logic [SumW-1:0] sum_blue;
      logic [CntW-1:0] kept;
   } acc_type;

endpackage
`default_nettype wire

// ===== src/bdmt_fifo.sv =====
`default_nettype none
module bdmt_fifo
   import bdmt_pkg::*;
(
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire logic      push,
   input  wire job_type   push_data,
   input  wire logic      pop,
   output job_type        pop_data,
   output qstat_type      stat
);

   job_type    slot_ff [2];
   logic       wr_ptr_ff;
   logic       rd_ptr_ff;
   logic [1:0] fill_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= 2'd0;
      end else begin
         if (push) begin
            wr_ptr_ff <= ~wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= ~rd_ptr_ff;
         end
         if (push && !pop) begin
            fill_ff <= fill_ff + 2'd1;
         end else if (pop && !push) begin
            fill_ff <= fill_ff - 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign pop_data   = slot_ff[rd_ptr_ff];
   assign stat.full  = (fill_ff == 2'd2);
   assign stat.empty = (fill_ff == 2'd0);

endmodule
`default_nettype wire

// ===== src/bdmt_front.sv =====
`default_nettype none
module bdmt_front
   import bdmt_pkg::*;
(
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire cfg_type   cfg,
   input  wire logic      cfg_wr,
   input  wire logic      req_valid,
   input  wire req_type   req_data,
   output logic           req_stall,
   input  wire qstat_type qstat,
   output logic           push,
   output job_type        job
);

   typedef enum logic [2:0] {
      F_IDLE, F_DIV, F_MUL, F_RD, F_UPD
   } fstate_type;

   typedef enum logic [1:0] {
      OP_STEP, OP_OUTW, OP_OUTH
   } op_type;

   fstate_type       state_ff;
   op_type           op_ff;
   req_type          pix_ff;
   logic             dirty_ff;
   logic [SideW:0]   dnum_ff;
   logic [SideW:0]   drem_ff;
   logic [SideW-1:0] dden_ff;
   logic [3:0]       dcnt_ff;
   logic [SideW-1:0] step_ff;
   logic [SideW-1:0] out_w_ff;
   logic [SideW-1:0] out_h_ff;
   logic [SideW-1:0] col_lim_ff;
   logic [SideW-1:0] row_lim_ff;
   logic [CntW-1:0]  n_ff;
   logic [ColW-1:0]  col_ff;
   logic [ColW-1:0]  row_ff;
   logic [SideW-1:0] pc_ff;
   logic [SideW-1:0] pr_ff;
   logic [SideW-1:0] oc_ff;

   acc_type          acc_mem [MaxWidth];
   acc_type          rd_ff;

   // Divider step
   logic [SideW:0]   trial;
   logic             qbit;
   logic [SideW:0]   rem_in;
   logic [SideW:0]   num_in;
   logic [SideW:0]   quot;
   logic [SideW-1:0] quot_clip;

   logic [SideW-1:0] big;
   logic [SideW:0]   step_num;
   logic [SideW-1:0] blk_w;
   logic [SideW-1:0] blk_h;
   logic [2*SideW-1:0] col_prod;
   logic [2*SideW-1:0] row_prod;
   logic [2*SideW-1:0] n_prod;

   logic             accept;
   logic             frame_start;
   logic             in_col;
   logic             in_row;
   logic             first;
   logic             blk_done;
   logic             kept;
   logic             last_col;
   logic             last_row;
   acc_type          acc_base;
   acc_type          acc_new;
   logic [SideW:0]   pc_inc;
   logic [SideW:0]   pr_inc;
   logic [SideW-1:0] oc_inc;
   logic [SideW-1:0] col_inc;
   logic [SideW-1:0] row_inc;

   assign accept      = (state_ff == F_IDLE) && req_valid && !qstat.full;
   assign req_stall   = !((state_ff == F_IDLE) && !qstat.full);
   assign frame_start = (col_ff == '0) && (row_ff == '0);

   assign big      = (cfg.width > cfg.height) ? cfg.width : cfg.height;
   assign step_num = {1'b0, big} + {1'b0, cfg.side_budget} - (SideW+1)'(1);

   assign trial     = {drem_ff[SideW-1:0], dnum_ff[SideW]};
   assign qbit      = (trial >= {1'b0, dden_ff});
   assign rem_in    = qbit ? (trial - {1'b0, dden_ff}) : trial;
   assign num_in    = {dnum_ff[SideW-1:0], qbit};
   assign quot      = num_in;
   assign quot_clip = (quot == '0) ? SideW'(1) : quot[SideW-1:0];

   assign blk_w    = (cfg.width < step_ff) ? cfg.width : step_ff;
   assign blk_h    = (cfg.height < step_ff) ? cfg.height : step_ff;
   assign col_prod = out_w_ff * blk_w;
   assign row_prod = out_h_ff * blk_h;
   assign n_prod   = blk_w * blk_h;

   assign in_col   = ({1'b0, col_ff} < col_lim_ff) && (oc_ff < out_w_ff);
   assign in_row   = ({1'b0, row_ff} < row_lim_ff);
   assign first    = (pr_ff == '0) && (pc_ff == '0);
   assign pc_inc   = {1'b0, pc_ff} + (SideW+1)'(1);
   assign pr_inc   = {1'b0, pr_ff} + (SideW+1)'(1);
   assign oc_inc   = oc_ff + SideW'(1);
   assign col_inc  = {1'b0, col_ff} + SideW'(1);
   assign row_inc  = {1'b0, row_ff} + SideW'(1);
   assign blk_done = (pr_inc >= {1'b0, blk_h}) && (pc_inc >= {1'b0, blk_w});
   assign kept     = (pix_ff.mask_value > MaskThresh) ^ cfg.invert_mask;
   assign last_col = (col_inc >= cfg.width);
   assign last_row = (row_inc >= cfg.height);

   assign acc_base          = first ? '0 : rd_ff;
   assign acc_new.sum_red   = acc_base.sum_red + SumW'(pix_ff.red);
   assign acc_new.sum_green = acc_base.sum_green + SumW'(pix_ff.green);
   assign acc_new.sum_blue  = acc_base.sum_blue + SumW'(pix_ff.blue);
   assign acc_new.kept      = acc_base.kept + CntW'(kept);

   assign push           = (state_ff == F_UPD) && in_col && in_row && blk_done;
   assign job.sum_red    = acc_new.sum_red;
   assign job.sum_green  = acc_new.sum_green;
   assign job.sum_blue   = acc_new.sum_blue;
   assign job.count      = n_ff;
   assign job.tint       = cfg.mask_enable && ({acc_new.kept, 1'b0} < {1'b0, n_ff});
   assign job.row_end    = (oc_inc == out_w_ff);
   assign job.frame_end  = (oc_inc == out_w_ff) && (row_inc == row_lim_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
         op_ff    <= OP_STEP;
         dirty_ff <= 1'b1;
         step_ff  <= SideW'(1);
         col_ff   <= '0;
         row_ff   <= '0;
         pc_ff    <= '0;
         pr_ff    <= '0;
         oc_ff    <= '0;
      end else begin
         if (cfg_wr) begin
            dirty_ff <= 1'b1;
         end else if (state_ff == F_MUL) begin
            dirty_ff <= 1'b0;
         end
         case (state_ff)
            F_IDLE: begin
               if (accept) begin
                  pix_ff <= req_data;
                  if (frame_start) begin
                     pc_ff <= '0;
                     pr_ff <= '0;
                     oc_ff <= '0;
                  end
                  dcnt_ff <= '0;
                  drem_ff <= '0;
                  if (frame_start && (cfg.side_budget != '0)) begin
                     state_ff <= F_DIV;
                     op_ff    <= OP_STEP;
                     dnum_ff  <= step_num;
                     dden_ff  <= cfg.side_budget;
                  end else if (frame_start || dirty_ff) begin
                     state_ff <= F_DIV;
                     op_ff    <= OP_OUTW;
                     dnum_ff  <= {1'b0, cfg.width};
                     if (frame_start) begin
                        step_ff <= SideW'(1);
                        dden_ff <= SideW'(1);
                     end else begin
                        dden_ff <= step_ff;
                     end
                  end else begin
                     state_ff <= F_RD;
                  end
               end
            end
            F_DIV: begin
               if (dcnt_ff == 4'(SideW)) begin
                  dcnt_ff <= '0;
                  drem_ff <= '0;
                  case (op_ff)
                     OP_STEP: begin
                        step_ff <= quot[SideW-1:0];
                        dden_ff <= quot[SideW-1:0];
                        dnum_ff <= {1'b0, cfg.width};
                        op_ff   <= OP_OUTW;
                     end
                     OP_OUTW: begin
                        out_w_ff <= quot_clip;
                        dnum_ff  <= {1'b0, cfg.height};
                        op_ff    <= OP_OUTH;
                     end
                     default: begin
                        out_h_ff <= quot_clip;
                        state_ff <= F_MUL;
                     end
                  endcase
               end else begin
                  dnum_ff <= num_in;
                  drem_ff <= rem_in;
                  dcnt_ff <= dcnt_ff + 4'd1;
               end
            end
            F_MUL: begin
               col_lim_ff <= col_prod[SideW-1:0];
               row_lim_ff <= row_prod[SideW-1:0];
               n_ff       <= n_prod[CntW-1:0];
               state_ff   <= F_RD;
            end
            F_RD: begin
               state_ff <= F_UPD;
            end
            F_UPD: begin
               state_ff <= F_IDLE;
               if (last_col) begin
                  col_ff <= '0;
                  pc_ff  <= '0;
                  oc_ff  <= '0;
                  if (last_row) begin
                     row_ff <= '0;
                     pr_ff  <= '0;
                  end else begin
                     row_ff <= row_inc[ColW-1:0];
                     if (in_row) begin
                        pr_ff <= (pr_inc >= {1'b0, blk_h}) ? '0 : pr_inc[SideW-1:0];
                     end
                  end
               end else begin
                  col_ff <= col_inc[ColW-1:0];
                  if (in_col && in_row) begin
                     if (pc_inc >= {1'b0, blk_w}) begin
                        pc_ff <= '0;
                        oc_ff <= oc_inc;
                     end else begin
                        pc_ff <= pc_inc[SideW-1:0];
                     end
                  end
               end
            end
            default: begin
               state_ff <= F_IDLE;
            end
         endcase
      end
   end

   // Column accumulator store: one read per pixel, and one write per pixel that falls inside an output block.
   always_ff @(posedge clock) begin
      if (state_ff == F_RD) begin
         rd_ff <= acc_mem[oc_ff[ColW-1:0]];
      end
      if ((state_ff == F_UPD) && in_col && in_row) begin
         acc_mem[oc_ff[ColW-1:0]] <= acc_new;
      end
   end

endmodule
`default_nettype wire

// ===== src/bdmt_back.sv =====
`default_nettype none
module bdmt_back
   import bdmt_pkg::*;
(
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire qstat_type qstat,
   input  wire job_type   job,
   output logic           pop,
   output logic           rsp_valid,
   output rsp_type        rsp_data,
   input  wire logic      rsp_stall
);

   typedef enum logic [1:0] {
      B_IDLE, B_DIV, B_OUT
   } bstate_type;

   bstate_type      state_ff;
   job_type         job_ff;
   logic [1:0]      ch_ff;
   logic [5:0]      cnt_ff;
   logic [SumW-1:0] num_ff;
   logic [CntW-1:0] rem_ff;
   logic [7:0]      avg_ff [3];
   logic            valid_ff;
   rsp_type         rsp_ff;

   logic [CntW:0]   trial;
   logic            qbit;
   logic [SumW-1:0] num_in;
   logic [CntW-1:0] rem_in;
   logic [15:0]     third [3];
   logic            out_free;
   rsp_type         rsp_in;

   assign trial  = {rem_ff, num_ff[SumW-1]};
   assign qbit   = (trial >= {1'b0, job_ff.count});
   assign rem_in = qbit ? CntW'(trial - {1'b0, job_ff.count}) : trial[CntW-1:0];
   assign num_in = {num_ff[SumW-2:0], qbit};

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         third[i] = 16'(avg_ff[i]) * 16'(RecipThird);
      end
   end

   always_comb begin
      rsp_in.tinted    = job_ff.tint;
      rsp_in.row_end   = job_ff.row_end;
      rsp_in.frame_end = job_ff.frame_end;
      if (job_ff.tint) begin
         rsp_in.out_red   = 8'(third[0] >> RecipShift) + TintOffset;
         rsp_in.out_green = 8'(third[1] >> RecipShift);
         rsp_in.out_blue  = 8'(third[2] >> RecipShift);
      end else begin
         rsp_in.out_red   = avg_ff[0];
         rsp_in.out_green = avg_ff[1];
         rsp_in.out_blue  = avg_ff[2];
      end
   end

   assign out_free  = !valid_ff || !rsp_stall;
   assign pop       = (state_ff == B_IDLE) && !qstat.empty;
   assign rsp_valid = valid_ff;
   assign rsp_data  = rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= B_IDLE;
         valid_ff <= 1'b0;
      end else begin
         if ((state_ff == B_OUT) && out_free) begin
            valid_ff <= 1'b1;
         end else if (valid_ff && !rsp_stall) begin
            valid_ff <= 1'b0;
         end
         case (state_ff)
            B_IDLE: begin
               if (pop) begin
                  job_ff   <= job;
                  num_ff   <= job.sum_red;
                  rem_ff   <= '0;
                  cnt_ff   <= '0;
                  ch_ff    <= '0;
                  state_ff <= B_DIV;
               end
            end
            B_DIV: begin
               if (cnt_ff == 6'(SumW - 1)) begin
                  avg_ff[ch_ff] <= num_in[7:0];
                  cnt_ff        <= '0;
                  rem_ff        <= '0;
                  ch_ff         <= ch_ff + 2'd1;
                  case (ch_ff)
                     2'd0: num_ff <= job_ff.sum_green;
                     2'd1: num_ff <= job_ff.sum_blue;
                     default: state_ff <= B_OUT;
                  endcase
               end else begin
                  num_ff <= num_in;
                  rem_ff <= rem_in;
                  cnt_ff <= cnt_ff + 6'd1;
               end
            end
            B_OUT: begin
               if (out_free) begin
                  rsp_ff   <= rsp_in;
                  state_ff <= B_IDLE;
               end
            end
            default: begin
               state_ff <= B_IDLE;
            end
         endcase
      end
   end

endmodule
`default_nettype wire

// ===== src/box_decimate_mask_tint.sv =====
`default_nettype none
// Channel   Ports                         Direction  Transfer when
// request   req_valid req_data req_stall  in         req_valid && !req_stall
// response  rsp_valid rsp_data rsp_stall  out        rsp_valid && !rsp_stall
// config    csr_we csr_index csr_wdata    in         csr_we
//
// An ordinary pixel passes through the front end as an accept, a read of the
// column accumulator store, and its write back. The first pixel of a frame
// first runs serial divisions for the step, output width and output height,
// then a multiply step; when the side budget is zero, or on the first pixel
// after a register write inside a frame, the step division is skipped. A
// finished block holds the back end for a pop, three serial divisions and an
// output step, and the back end runs alongside the front end behind a
// two-entry queue. Reset is synchronous and clears control state; the
// accumulator store is not cleared. req_stall is high whenever the front end
// is busy or the queue is full; a waiting result holds in the output register
// while rsp_stall is high.
module box_decimate_mask_tint
   import bdmt_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   input  wire req_type             req_data,
   output logic                     req_stall,
   output logic                     rsp_valid,
   output rsp_type                  rsp_data,
   input  wire logic                rsp_stall,
   input  wire logic                csr_we,
   input  wire logic [CsrIdxW-1:0]  csr_index,
   input  wire logic [CsrDataW-1:0] csr_wdata
);

   logic [SideW-1:0] src_width_ff;
   logic [SideW-1:0] src_height_ff;
   logic [SideW-1:0] side_budget_ff;
   logic             mask_enable_ff;
   logic             invert_mask_ff;

   cfg_type   cfg;
   qstat_type qstat;
   logic      q_push;
   logic      q_pop;
   job_type   q_in;
   job_type   q_out;

   // Register file. Writes to unused indexes are dropped.
   always_ff @(posedge clock) begin
      if (reset) begin
         src_width_ff   <= SideW'(1);
         src_height_ff  <= SideW'(1);
         side_budget_ff <= '0;
         mask_enable_ff <= 1'b0;
         invert_mask_ff <= 1'b0;
      end else if (csr_we) begin
         case (csr_index)
            CsrSrcWidth:   src_width_ff   <= csr_wdata;
            CsrSrcHeight:  src_height_ff  <= csr_wdata;
            CsrMaxSide:    side_budget_ff <= csr_wdata;
            CsrMaskEnable: mask_enable_ff <= csr_wdata[0];
            CsrInvertMask: invert_mask_ff <= csr_wdata[0];
            default: begin
            end
         endcase
      end
   end

   // Sizes of zero count as one and sizes beyond the store saturate.
   always_comb begin
      cfg.width = (src_width_ff == '0) ? SideW'(1) :
                  (src_width_ff > MaxWidthSide) ? MaxWidthSide : src_width_ff;
      cfg.height = (src_height_ff == '0) ? SideW'(1) :
                   (src_height_ff > MaxHeightSide) ? MaxHeightSide : src_height_ff;
      cfg.side_budget = side_budget_ff;
      cfg.mask_enable = mask_enable_ff;
      cfg.invert_mask = invert_mask_ff;
   end

   bdmt_front u_front (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .cfg_wr    (csr_we),
      .req_valid (req_valid),
      .req_data  (req_data),
      .req_stall (req_stall),
      .qstat     (qstat),
      .push      (q_push),
      .job       (q_in)
   );

   bdmt_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_in),
      .pop       (q_pop),
      .pop_data  (q_out),
      .stat      (qstat)
   );

   bdmt_back u_back (
      .clock     (clock),
      .reset     (reset),
      .qstat     (qstat),
      .job       (q_out),
      .pop       (q_pop),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .rsp_stall (rsp_stall)
   );

   // The front end checks for room before it takes a pixel, so a block
   // never lands in a full queue.
   a_no_overflow : assert property (@(posedge clock) disable iff (reset)
      !(q_push && qstat.full && !q_pop))
      else $error("block queue overflow");

   // One pixel at a time: right after a transfer the front end is busy.
   a_busy_after_accept : assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("front end took two pixels back to back");

   // The last pixel of a frame also closes its output row.
   a_frame_end_row : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (!rsp_data.frame_end || rsp_data.row_end))
      else $error("frame end without row end");

   // The back end only pops when the queue holds a block.
   a_no_underflow : assert property (@(posedge clock) disable iff (reset)
      q_pop |-> !qstat.empty)
      else $error("block queue underflow");

endmodule
`default_nettype wire
